FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: sv/bplm_pkg.sv
// ----------------------------------------------------------------------------
// bplm_pkg
// Shared types, request and status codes and width helpers for the buffer
// pool list manager.
// ----------------------------------------------------------------------------
package bplm_pkg;

	// Default pool size.
	localparam int BUFFER_COUNT_DEF = 64;

	// Fixed field widths of the request and response.
	localparam int REQ_W    = 3;
	localparam int FIELD_W  = 6;
	localparam int STATUS_W = 2;
	localparam int TAG_W    = 2;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_GET_FREE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_GET_READY = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ADD_READY = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PUT_BACK  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RELEASE   = 3'd4;

	// Response status codes.
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_BUSY = 2'd2;

	// List membership of one buffer.
	typedef enum logic [TAG_W-1:0] {
		TAG_FREE  = 2'd0,
		TAG_READY = 2'd1,
		TAG_BUSY  = 2'd2
	} tag_t;

	// Commands to the free stack.
	typedef struct packed {
		logic pop;
		logic push;
	} stk_cmd_t;

	// Commands to the ready queue.
	typedef struct packed {
		logic pop;
		logic push_head;
		logic push_tail;
	} que_cmd_t;

	// Width of a buffer index for a pool of n buffers.
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// Width of a count that can hold n itself.
	function automatic int cnt_w(input int n);
		return $clog2(n + 1);
	endfunction

endpackage

FILE: sv/bplm_ram.sv
// ----------------------------------------------------------------------------
// bplm_ram
// Single-port-write, single-port-read memory with registered read data.
// A read of the address written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module bplm_ram #(
	parameter int DEPTH = bplm_pkg::BUFFER_COUNT_DEF,
	parameter int WIDTH = bplm_pkg::TAG_W,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port, and read port with write-first forwarding.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem_q[rd_addr];
			end
		end
	end

endmodule

FILE: sv/bplm_free_stack.sv
// ----------------------------------------------------------------------------
// bplm_free_stack
// Free list kept as a stack in memory. The top entry is held in a register
// and the entry below it is read from memory in advance, so a pop or a
// push can happen in every cycle. Positions below the lowest fill level seen
// since reset still hold their reset content and are never read from memory.
// ----------------------------------------------------------------------------
module bplm_free_stack #(
	parameter int BUFFER_COUNT = bplm_pkg::BUFFER_COUNT_DEF,
	localparam int IW = bplm_pkg::idx_w(BUFFER_COUNT),
	localparam int CW = bplm_pkg::cnt_w(BUFFER_COUNT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bplm_pkg::stk_cmd_t cmd,
	input  logic [IW-1:0]      push_data,
	output logic [IW-1:0]      top,
	output logic [CW-1:0]      count,
	output logic [CW-1:0]      low_mark_next
);

	import bplm_pkg::*;

	localparam logic [IW-1:0] MAX_IDX = IW'(BUFFER_COUNT - 1);
	localparam logic [IW-1:0] POS_RST = IW'((BUFFER_COUNT > 1) ? BUFFER_COUNT - 2 : 0);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] low_q;
	logic [CW-1:0] low_d;
	logic [CW-1:0] sec_pos;
	logic [IW-1:0] top_q;
	logic [IW-1:0] top_d;
	logic [IW-1:0] rd_pos_q;
	logic [IW-1:0] ram_rd;
	logic [IW-1:0] sec_val;
	logic          init_q;
	logic          init_d;

	// Next fill level, low-water mark and the position below the new top.
	always_comb begin
		count_d = count_q;
		if (cmd.pop) begin
			count_d = count_q - CW'(1);
		end else if (cmd.push) begin
			count_d = count_q + CW'(1);
		end
		low_d   = (count_d < low_q) ? count_d : low_q;
		sec_pos = count_d - CW'(2);
		init_d  = (sec_pos < low_d);
	end

	// Entry below the top: reset content where it was never overwritten.
	assign sec_val = init_q ? (MAX_IDX - rd_pos_q) : ram_rd;

	// Next top of stack.
	always_comb begin
		top_d = top_q;
		if (cmd.pop) begin
			top_d = sec_val;
		end else if (cmd.push) begin
			top_d = push_data;
		end
	end

	bplm_ram #(
		.DEPTH (BUFFER_COUNT),
		.WIDTH (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (count_q[IW-1:0]),
		.wr_data (push_data),
		.rd_en   (1'b1),
		.rd_addr (sec_pos[IW-1:0]),
		.rd_data (ram_rd)
	);

	// Stack pointer, low-water mark and cached top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= CW'(BUFFER_COUNT);
			low_q    <= CW'(BUFFER_COUNT);
			top_q    <= '0;
			rd_pos_q <= POS_RST;
			init_q   <= 1'b1;
		end else begin
			count_q  <= count_d;
			low_q    <= low_d;
			top_q    <= top_d;
			rd_pos_q <= sec_pos[IW-1:0];
			init_q   <= init_d;
		end
	end

	assign top           = top_q;
	assign count         = count_q;
	assign low_mark_next = low_d;

endmodule

FILE: sv/bplm_ready_queue.sv
// ----------------------------------------------------------------------------
// bplm_ready_queue
// Ready list kept as a circular double-ended queue in memory. The head entry
// is held in a register and the entry after it is read in advance, so a
// pop or a push at either end can happen in every cycle.
// ----------------------------------------------------------------------------
module bplm_ready_queue #(
	parameter int BUFFER_COUNT = bplm_pkg::BUFFER_COUNT_DEF,
	localparam int IW = bplm_pkg::idx_w(BUFFER_COUNT),
	localparam int CW = bplm_pkg::cnt_w(BUFFER_COUNT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bplm_pkg::que_cmd_t cmd,
	input  logic [IW-1:0]      push_data,
	output logic [IW-1:0]      head,
	output logic [CW-1:0]      count
);

	import bplm_pkg::*;

	localparam int SW = CW + 1;
	localparam logic [IW-1:0] LAST = IW'(BUFFER_COUNT - 1);

	logic [IW-1:0] hp_q;
	logic [IW-1:0] hp_d;
	logic [IW-1:0] hp_dec;
	logic [IW-1:0] head_q;
	logic [IW-1:0] head_d;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] tail_pos;
	logic [IW-1:0] ram_rd;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic [SW-1:0] tail_sum;
	logic          wr_en;

	// Slot before the head and slot after the tail, both modulo the pool size.
	always_comb begin
		hp_dec   = (hp_q == '0) ? LAST : (hp_q - IW'(1));
		tail_sum = SW'(hp_q) + SW'(cnt_q);
		if (tail_sum >= SW'(BUFFER_COUNT)) begin
			tail_pos = IW'(tail_sum - SW'(BUFFER_COUNT));
		end else begin
			tail_pos = IW'(tail_sum);
		end
	end

	// Pointer, count and head updates.
	always_comb begin
		hp_d    = hp_q;
		head_d  = head_q;
		cnt_d   = cnt_q;
		wr_addr = tail_pos;
		wr_en   = cmd.push_head || cmd.push_tail;
		if (cmd.pop) begin
			hp_d   = (hp_q == LAST) ? '0 : (hp_q + IW'(1));
			head_d = ram_rd;
			cnt_d  = cnt_q - CW'(1);
		end else if (cmd.push_head) begin
			hp_d    = hp_dec;
			head_d  = push_data;
			wr_addr = hp_dec;
			cnt_d   = cnt_q + CW'(1);
		end else if (cmd.push_tail) begin
			if (cnt_q == '0) begin
				head_d = push_data;
			end
			cnt_d = cnt_q + CW'(1);
		end
		rd_addr = (hp_d == LAST) ? '0 : (hp_d + IW'(1));
	end

	bplm_ram #(
		.DEPTH (BUFFER_COUNT),
		.WIDTH (IW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (push_data),
		.rd_en   (1'b1),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// Queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q  <= '0;
			cnt_q <= '0;
		end else begin
			hp_q  <= hp_d;
			cnt_q <= cnt_d;
		end
	end

	// Cached head entry; only meaningful while the queue holds entries.
	always_ff @(posedge clk) begin
		head_q <= head_d;
	end

	assign head  = head_q;
	assign count = cnt_q;

endmodule

FILE: sv/buffer_pool_list_manager.sv
// ----------------------------------------------------------------------------
// buffer_pool_list_manager
// Hands out and takes back buffer indices of a fixed pool kept on a free
// list, a ready list and a busy set.
//
// Request channel (req_valid, req_stall): req_type, buffer_index and
// buffer_is_empty. Response channel (rsp_valid, rsp_stall): status and
// granted_index, one response per request, in request order.
// A taken request is decoded from the request register, and its response is
// then registered in the response register, which presents it.
// One request per cycle is sustained while rsp_stall is low; the limit is the
// single read and write port of each list and membership tag memory.
// Reset empties the pipeline and puts every buffer on the free list in index
// order, so that get free hands out 0, 1, 2 and so on. No clearing pass runs.
// While rsp_stall is high the response register holds; the request stage
// still takes one request, then req_stall rises until the response moves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buffer_pool_list_manager #(
	parameter int BUFFER_COUNT = bplm_pkg::BUFFER_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [bplm_pkg::REQ_W-1:0]    req_type,
	input  logic [bplm_pkg::FIELD_W-1:0]  buffer_index,
	input  logic                          buffer_is_empty,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bplm_pkg::STATUS_W-1:0] status,
	output logic [bplm_pkg::FIELD_W-1:0]  granted_index
);

	import bplm_pkg::*;

	localparam int IW = idx_w(BUFFER_COUNT);
	localparam int CW = cnt_w(BUFFER_COUNT);

	// Request stage.
	logic                v_s1;
	logic [REQ_W-1:0]    req_s1;
	logic [IW-1:0]       idx_s1;
	logic                oor_s1;
	logic                empty_s1;
	logic                fresh_s1;

	// Response stage.
	logic                v_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [FIELD_W-1:0]  grant_s2;

	logic                accept;
	logic                adv;
	logic [IW-1:0]       tag_raddr;
	logic [TAG_W-1:0]    tag_rd;
	logic [TAG_W-1:0]    tag_eff;
	logic                fresh_d;
	logic                busy;
	logic                tag_we;
	logic [IW-1:0]       tag_waddr;
	logic [TAG_W-1:0]    tag_wdata;
	logic [STATUS_W-1:0] status_d;
	logic [FIELD_W-1:0]  grant_d;
	stk_cmd_t            stk_cmd;
	que_cmd_t            que_cmd;
	logic [IW-1:0]       free_top;
	logic [CW-1:0]       free_cnt;
	logic [CW-1:0]       low_next;
	logic [IW-1:0]       rdy_head;
	logic [CW-1:0]       rdy_cnt;

	// Handshake: the request stage moves on whenever the response register
	// is empty or being read out.
	assign adv       = v_s1 && (!v_s2 || !rsp_stall);
	assign req_stall = v_s1 && !adv;
	assign accept    = req_valid && !req_stall;

	// Membership tag lookup, issued as the request is taken. A buffer whose
	// index is at least the pool size less the free stack's low-water mark
	// has never left the free list, so its tag is free without reading memory.
	assign tag_raddr = IW'(buffer_index);
	assign fresh_d   = CW'(tag_raddr) < (CW'(BUFFER_COUNT) - low_next);

	bplm_ram #(
		.DEPTH (BUFFER_COUNT),
		.WIDTH (TAG_W)
	) u_tag_ram (
		.clk     (clk),
		.wr_en   (tag_we),
		.wr_addr (tag_waddr),
		.wr_data (tag_wdata),
		.rd_en   (accept),
		.rd_addr (tag_raddr),
		.rd_data (tag_rd)
	);

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= req_type;
			idx_s1   <= tag_raddr;
			oor_s1   <= (32'(buffer_index) >= 32'(BUFFER_COUNT));
			empty_s1 <= buffer_is_empty;
			fresh_s1 <= fresh_d;
		end
	end

	assign tag_eff = fresh_s1 ? tag_rd : TAG_FREE;
	assign busy    = !oor_s1 && (tag_eff == TAG_BUSY);

	// Request decode: list moves, tag update and response.
	always_comb begin
		stk_cmd   = '0;
		que_cmd   = '0;
		tag_we    = 1'b0;
		tag_waddr = idx_s1;
		tag_wdata = TAG_BUSY;
		status_d  = ST_DONE;
		grant_d   = '0;
		case (req_s1)
			REQ_GET_FREE: begin
				if (free_cnt != '0) begin
					stk_cmd.pop = 1'b1;
					tag_we      = 1'b1;
					tag_waddr   = free_top;
					grant_d     = FIELD_W'(free_top);
				end else begin
					status_d = ST_EMPTY;
				end
			end
			REQ_GET_READY: begin
				if (rdy_cnt != '0) begin
					que_cmd.pop = 1'b1;
					tag_we      = 1'b1;
					tag_waddr   = rdy_head;
					grant_d     = FIELD_W'(rdy_head);
				end else begin
					status_d = ST_EMPTY;
				end
			end
			REQ_ADD_READY: begin
				if (busy) begin
					que_cmd.push_tail = 1'b1;
					tag_we            = 1'b1;
					tag_wdata         = TAG_READY;
				end else begin
					status_d = ST_NOT_BUSY;
				end
			end
			REQ_PUT_BACK: begin
				if (!busy) begin
					status_d = ST_NOT_BUSY;
				end else if (empty_s1) begin
					stk_cmd.push = 1'b1;
					tag_we       = 1'b1;
					tag_wdata    = TAG_FREE;
				end else begin
					que_cmd.push_head = 1'b1;
					tag_we            = 1'b1;
					tag_wdata         = TAG_READY;
				end
			end
			REQ_RELEASE: begin
				if (busy) begin
					stk_cmd.push = 1'b1;
					tag_we       = 1'b1;
					tag_wdata    = TAG_FREE;
				end else begin
					status_d = ST_NOT_BUSY;
				end
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
		if (!adv) begin
			stk_cmd = '0;
			que_cmd = '0;
			tag_we  = 1'b0;
		end
	end

	bplm_free_stack #(
		.BUFFER_COUNT (BUFFER_COUNT)
	) u_free_stack (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (stk_cmd),
		.push_data     (idx_s1),
		.top           (free_top),
		.count         (free_cnt),
		.low_mark_next (low_next)
	);

	bplm_ready_queue #(
		.BUFFER_COUNT (BUFFER_COUNT)
	) u_ready_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (que_cmd),
		.push_data (idx_s1),
		.head      (rdy_head),
		.count     (rdy_cnt)
	);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s2 <= status_d;
			grant_s2  <= grant_d;
		end
	end

	assign rsp_valid     = v_s2;
	assign status        = status_s2;
	assign granted_index = grant_s2;

	// The free and ready lists together never hold more than the pool.
	`ASSERT_ALWAYS(a_pool_bound, (32'(free_cnt) + 32'(rdy_cnt)) <= 32'(BUFFER_COUNT), "pool over")
	// A pop of the ready queue only happens while it holds entries.
	`ASSERT_IMPL(a_ready_pop_live, que_cmd.pop, rdy_cnt != '0, "ready queue underflow")
	// A push onto the free stack never overflows the pool.
	`ASSERT_IMPL(a_free_push_room, stk_cmd.push, free_cnt < CW'(BUFFER_COUNT), "free overflow")
	// Only a successful get hands out a nonzero index.
	`ASSERT_IMPL(a_grant_zero, rsp_valid && (status != ST_DONE), granted_index == '0, "bad grant")

endmodule

FILE: verif/buffer_pool_list_manager_test.sv
// ----------------------------------------------------------------------------
// buffer_pool_list_manager_test
// Self-checking testbench for the buffer pool list manager. A behavioral
// copy of the free, ready and busy lists predicts the response to every
// accepted request, and each response transfer is compared in order.
// Stimulus runs directed cases, a full drain of the free list, biased
// random traffic and a long response hold-off that backs up the requests.
// ----------------------------------------------------------------------------
module buffer_pool_list_manager_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bplm_pkg::*;

	localparam int POOL_SIZE       = BUFFER_COUNT_DEF;
	localparam int LINK_W          = 7;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SIZE);
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int HOLD_OFF_CYCLES = 250;
	localparam int RANDOM_ITEMS    = 560;
	localparam int PRESSURE_ITEMS  = 40;

	// Request codes the block does not define; it must answer them as done.
	localparam logic [REQ_W-1:0] REQ_SPARE_5 = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  granted;
	} reply_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                req_valid       = 1'b0;
	logic                req_stall;
	logic [REQ_W-1:0]    req_type        = REQ_GET_FREE;
	logic [FIELD_W-1:0]  buffer_index    = '0;
	logic                buffer_is_empty = 1'b0;
	logic                rsp_valid;
	logic                rsp_stall       = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [FIELD_W-1:0]  granted_index;

	// Predicted pool state, updated at every request transfer.
	tag_t              pool_tag  [POOL_SIZE];
	logic [LINK_W-1:0] pool_next [POOL_SIZE];
	logic [LINK_W-1:0] pool_prev [POOL_SIZE];
	logic [LINK_W-1:0] list_head [3];
	logic [LINK_W-1:0] list_tail [3];

	reply_t pending_replies[$];
	int     error_count = 0;
	int     idle_cycles = 0;

	// Sender burst state and the hold-off handshake to the receiver.
	int burst_left     = 0;
	bit sender_steady  = 1'b0;
	int hold_off_seq   = 0;
	int hold_off_seen  = 0;
	int hold_off_left  = 0;

	buffer_pool_list_manager DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.buffer_index    (buffer_index),
		.buffer_is_empty (buffer_is_empty),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.status          (status),
		.granted_index   (granted_index)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Remove a buffer from whichever list it is on, fixing neighbors and ends.
	function automatic void unlink_buffer(input logic [LINK_W-1:0] b);
		tag_t              owner;
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		owner = pool_tag[b];
		p     = pool_prev[b];
		n     = pool_next[b];
		if (p != NIL) pool_next[p] = n;
		else list_head[owner] = n;
		if (n != NIL) pool_prev[n] = p;
		else list_tail[owner] = p;
		pool_next[b] = NIL;
		pool_prev[b] = NIL;
	endfunction

	function automatic void append_buffer(input tag_t owner, input logic [LINK_W-1:0] b);
		logic [LINK_W-1:0] t;
		t            = list_tail[owner];
		pool_tag[b]  = owner;
		pool_next[b] = NIL;
		pool_prev[b] = t;
		if (t != NIL) pool_next[t] = b;
		else list_head[owner] = b;
		list_tail[owner] = b;
	endfunction

	function automatic void prepend_buffer(input tag_t owner, input logic [LINK_W-1:0] b);
		logic [LINK_W-1:0] h;
		h            = list_head[owner];
		pool_tag[b]  = owner;
		pool_prev[b] = NIL;
		pool_next[b] = h;
		if (h != NIL) pool_prev[h] = b;
		else list_tail[owner] = b;
		list_head[owner] = b;
	endfunction

	// Apply one request to the predicted pool and return its response.
	function automatic reply_t predict_reply(input logic [REQ_W-1:0] kind,
			input logic [FIELD_W-1:0] idx, input logic empty);
		reply_t            r;
		tag_t              src;
		logic [LINK_W-1:0] h;
		logic [LINK_W-1:0] b;
		r.status  = ST_DONE;
		r.granted = '0;
		b         = LINK_W'(idx);
		case (kind)
			REQ_GET_FREE, REQ_GET_READY: begin
				if (kind == REQ_GET_FREE) src = TAG_FREE;
				else src = TAG_READY;
				h = list_head[src];
				if (h != NIL) begin
					unlink_buffer(h);
					append_buffer(TAG_BUSY, h);
					r.granted = h[FIELD_W-1:0];
				end else begin
					r.status = ST_EMPTY;
				end
			end
			REQ_ADD_READY, REQ_PUT_BACK, REQ_RELEASE: begin
				if (pool_tag[b] != TAG_BUSY) begin
					r.status = ST_NOT_BUSY;
				end else begin
					unlink_buffer(b);
					// An empty buffer on put back goes to the free list only.
					if (kind == REQ_ADD_READY) append_buffer(TAG_READY, b);
					else if (kind == REQ_PUT_BACK && !empty) prepend_buffer(TAG_READY, b);
					else prepend_buffer(TAG_FREE, b);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Pick a random buffer currently on the busy list.
	function automatic bit pick_busy(output logic [FIELD_W-1:0] idx);
		int hits[$];
		idx = '0;
		foreach (pool_tag[i]) if (pool_tag[i] == TAG_BUSY) hits.push_back(i);
		if (hits.size() == 0) return 1'b0;
		idx = FIELD_W'(hits[$urandom_range(0, hits.size() - 1)]);
		return 1'b1;
	endfunction

	// Predict at each request transfer, check each response transfer, and
	// end the run when nothing has moved for too long.
	always @(posedge clk) begin : scoreboard
		reply_t want;
		if (!arst_n) begin
			foreach (pool_tag[i]) begin
				pool_tag[i]  = TAG_FREE;
				pool_next[i] = LINK_W'(i + 1);
				pool_prev[i] = (i == 0) ? NIL : LINK_W'(i - 1);
			end
			list_head[TAG_FREE]  = '0;
			list_tail[TAG_FREE]  = LINK_W'(POOL_SIZE - 1);
			list_head[TAG_READY] = NIL;
			list_tail[TAG_READY] = NIL;
			list_head[TAG_BUSY]  = NIL;
			list_tail[TAG_BUSY]  = NIL;
			pending_replies.delete();
			idle_cycles = 0;
		end else begin
			if (req_valid && !req_stall)
				pending_replies.push_back(predict_reply(req_type, buffer_index,
					buffer_is_empty));
			if (rsp_valid && !rsp_stall) begin
				if (pending_replies.size() == 0) begin
					error_count++;
					$display("%0t: unexpected response, expected none, actual status %0d index %0d",
						$time, status, granted_index);
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						error_count++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
					end
					if (granted_index !== want.granted) begin
						error_count++;
						$display("%0t: granted_index expected %0d actual %0d",
							$time, want.granted, granted_index);
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Response stall pattern: random segments of open, coin-flip, sparse and
	// periodic stalling, overridden by a requested long hold-off.
	always @(negedge clk) begin : receiver_pattern
		static rx_mode_t rx_mode     = RX_OPEN;
		static int       segment_left = 0;
		logic            stall_next;
		if (hold_off_seq != hold_off_seen) begin
			hold_off_seen = hold_off_seq;
			hold_off_left = HOLD_OFF_CYCLES;
		end
		if (hold_off_left > 0) begin
			hold_off_left--;
			stall_next = 1'b1;
		end else begin
			if (segment_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				segment_left = $urandom_range(4, 40);
			end
			segment_left--;
			case (rx_mode)
				RX_COIN:     stall_next = 1'($urandom_range(0, 1));
				RX_SPARSE:   stall_next = ($urandom_range(0, 4) == 0);
				RX_PERIODIC: stall_next = (segment_left % 4) != 0;
				default:     stall_next = 1'b0;
			endcase
		end
		rsp_stall <= stall_next;
	end

	// Send one request. Called and returns at a falling edge; the sender
	// works in bursts and may drop valid between them.
	task automatic send_request(input logic [REQ_W-1:0] kind,
			input logic [FIELD_W-1:0] idx, input logic empty);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0 || sender_steady) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_valid       <= 1'b1;
		req_type        <= kind;
		buffer_index    <= idx;
		buffer_is_empty <= empty;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// One random request, mostly well formed. The bias either drains the free
	// list toward the busy and ready lists or returns buffers to it.
	task automatic send_random_request(input bit acquire_bias);
		int                 roll;
		logic [REQ_W-1:0]   kind;
		logic [FIELD_W-1:0] idx;
		logic               empty;
		roll  = $urandom_range(0, 99);
		idx   = FIELD_W'($urandom_range(0, POOL_SIZE - 1));
		empty = 1'($urandom_range(0, 1));
		if (roll < 5) begin
			kind = REQ_W'($urandom_range(0, 7));
		end else begin
			if (acquire_bias) begin
				if (roll < 45) kind = REQ_GET_FREE;
				else if (roll < 65) kind = REQ_GET_READY;
				else if (roll < 80) kind = REQ_ADD_READY;
				else if (roll < 92) kind = REQ_PUT_BACK;
				else kind = REQ_RELEASE;
			end else begin
				if (roll < 20) kind = REQ_GET_FREE;
				else if (roll < 35) kind = REQ_GET_READY;
				else if (roll < 55) kind = REQ_ADD_READY;
				else if (roll < 78) kind = REQ_PUT_BACK;
				else kind = REQ_RELEASE;
			end
			if (kind == REQ_ADD_READY || kind == REQ_PUT_BACK || kind == REQ_RELEASE)
				if (!pick_busy(idx)) kind = REQ_GET_FREE;
		end
		send_request(kind, idx, empty);
	endtask

	// Reset order, every request kind, empty lists, not-busy buffers, empty
	// put back and the undefined request codes.
	task automatic test_directed_cases();
		send_request(REQ_GET_READY, 6'd0, 1'b0);
		send_request(REQ_RELEASE, 6'd63, 1'b1);
		send_request(REQ_PUT_BACK, 6'd0, 1'b0);
		repeat (4) send_request(REQ_GET_FREE, 6'd63, 1'b1);
		send_request(REQ_ADD_READY, 6'd0, 1'b0);
		send_request(REQ_PUT_BACK, 6'd1, 1'b0);
		send_request(REQ_PUT_BACK, 6'd2, 1'b1);
		send_request(REQ_ADD_READY, 6'd0, 1'b1);
		send_request(REQ_SPARE_5, 6'd63, 1'b1);
		send_request(REQ_SPARE_6, 6'd0, 1'b0);
		send_request(REQ_SPARE_7, 6'd42, 1'b1);
		repeat (3) send_request(REQ_GET_READY, 6'd21, 1'b0);
		send_request(REQ_GET_FREE, 6'd0, 1'b0);
		send_request(REQ_RELEASE, 6'd0, 1'b0);
		send_request(REQ_RELEASE, 6'd1, 1'b1);
		send_request(REQ_RELEASE, 6'd2, 1'b0);
		send_request(REQ_RELEASE, 6'd3, 1'b1);
		send_request(REQ_GET_FREE, 6'd0, 1'b1);
		send_request(REQ_RELEASE, 6'd3, 1'b0);
	endtask

	// Take every buffer, hit the empty free list, then hand all of them back
	// through each return path, highest index first.
	task automatic test_drain_and_refill();
		int k;
		while (list_head[TAG_FREE] != NIL)
			send_request(REQ_GET_FREE, FIELD_W'($urandom), 1'($urandom));
		send_request(REQ_GET_FREE, 6'd63, 1'b0);
		for (k = POOL_SIZE - 1; k >= 0; k--) begin
			if (pool_tag[k] == TAG_BUSY) begin
				case (k % 4)
					0:       send_request(REQ_ADD_READY, FIELD_W'(k), 1'b1);
					1:       send_request(REQ_PUT_BACK, FIELD_W'(k), 1'b0);
					2:       send_request(REQ_PUT_BACK, FIELD_W'(k), 1'b1);
					default: send_request(REQ_RELEASE, FIELD_W'(k), 1'b0);
				endcase
			end
		end
		while (list_head[TAG_READY] != NIL) send_request(REQ_GET_READY, 6'd0, 1'b1);
		send_request(REQ_GET_READY, 6'd63, 1'b1);
	endtask

	// Long random run; the bias flips every hundred requests so the lists
	// swing between nearly full and nearly empty.
	task automatic test_random_traffic();
		int n;
		for (n = 0; n < RANDOM_ITEMS; n++) send_random_request(((n / 100) % 2) == 0);
	endtask

	// Hold the response side off while requests keep coming, so the block
	// fills and stalls its request channel.
	task automatic test_backpressure();
		int n;
		sender_steady = 1'b1;
		hold_off_seq++;
		for (n = 0; n < PRESSURE_ITEMS; n++) send_random_request(n < PRESSURE_ITEMS / 2);
		sender_steady = 1'b0;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_drain_and_refill();
		test_random_traffic();
		test_backpressure();
		req_valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (error_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: buffer_pool_list_manager.f
+incdir+sv
sv/bplm_pkg.sv
sv/bplm_ram.sv
sv/bplm_free_stack.sv
sv/bplm_ready_queue.sv
sv/buffer_pool_list_manager.sv
verif/buffer_pool_list_manager_test.sv
